### design/qsbp_pkg.sv
// ----------------------------------------------------------------------------
// qsbp_pkg
// Shared types, codes and lookup functions of the QR segment bit packer.
// ----------------------------------------------------------------------------
package qsbp_pkg;

    // Width of the running bit counter; wraps modulo 2^BIT_COUNTER_WIDTH.
    localparam int BIT_COUNTER_WIDTH = 15;

    // Request types
    localparam logic [1:0] REQ_HEADER = 2'd0;
    localparam logic [1:0] REQ_CHAR   = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    // Segment modes
    localparam logic [1:0] MODE_NUMERIC = 2'd0;
    localparam logic [1:0] MODE_ALNUM   = 2'd1;
    localparam logic [1:0] MODE_BYTE    = 2'd2;

    // Configuration register indexes
    localparam logic CFG_VERSION_GRADE = 1'b0;
    localparam logic CFG_CAPACITY_BITS = 1'b1;

    localparam logic [14:0] CAPACITY_RESET = 15'd152;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  mode_code;
        logic [15:0] seg_count;
        logic [7:0]  char_code;
    } req_word_t;

    typedef struct packed {
        logic [15:0] group_value;
        logic [4:0]  group_width;
        logic        last_of_run;
        logic        bad_input;
        logic [14:0] bits_so_far;
    } grp_word_t;

    // Character count field width by grade and mode; grade three acts as two.
    function automatic logic [4:0] count_width(input logic [1:0] grade,
                                               input logic [1:0] mode);
        logic [4:0] w;
        case (grade)
            2'd0:
            begin
                case (mode)
                    MODE_NUMERIC: w = 5'd10;
                    MODE_ALNUM:   w = 5'd9;
                    default:      w = 5'd8;
                endcase
            end
            2'd1:
            begin
                case (mode)
                    MODE_NUMERIC: w = 5'd12;
                    MODE_ALNUM:   w = 5'd11;
                    default:      w = 5'd16;
                endcase
            end
            default:
            begin
                case (mode)
                    MODE_NUMERIC: w = 5'd14;
                    MODE_ALNUM:   w = 5'd13;
                    default:      w = 5'd16;
                endcase
            end
        endcase
        return w;
    endfunction

    // Alphanumeric symbol table: bit 6 flags a valid symbol, bits 5:0 its value.
    function automatic logic [6:0] alnum_code(input logic [7:0] c);
        logic [6:0] r;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 6'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = {1'b1, 6'(c - 8'h41 + 8'd10)};
        end
        else
        begin
            case (c)
                8'h20:   r = {1'b1, 6'd36};
                8'h24:   r = {1'b1, 6'd37};
                8'h25:   r = {1'b1, 6'd38};
                8'h2A:   r = {1'b1, 6'd39};
                8'h2B:   r = {1'b1, 6'd40};
                8'h2D:   r = {1'b1, 6'd41};
                8'h2E:   r = {1'b1, 6'd42};
                8'h2F:   r = {1'b1, 6'd43};
                8'h3A:   r = {1'b1, 6'd44};
                default: r = 7'd0;
            endcase
        end
        return r;
    endfunction

endpackage

### design/qsbp_if.sv
// ----------------------------------------------------------------------------
// qsbp_if
// Valid/ready channels of the packer: request words in, bit group words out.
// ----------------------------------------------------------------------------
interface qsbp_req_if
    import qsbp_pkg::*;
;
    logic      valid;
    logic      ready;
    req_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface qsbp_grp_if
    import qsbp_pkg::*;
;
    logic      valid;
    logic      ready;
    grp_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### design/qr_segment_bit_packer.sv
// ----------------------------------------------------------------------------
// qr_segment_bit_packer
// Packs QR data segments (headers, characters, finish) into bit groups.
// ----------------------------------------------------------------------------
// Latency: a group word is presented the cycle after its request is accepted.
// Throughput: one request per cycle while each makes one group word and the output
// is ready; a request making two words (header, or terminator plus padding) holds the
// input until its first word is taken, as the two-slot result register drains one word per cycle while grp.ready.
// Reset (rst_n low, asynchronous): segment closed, bit counter zero,
// version_grade 0, capacity_bits 152, result register empty.
// ----------------------------------------------------------------------------
module qr_segment_bit_packer
    import qsbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    qsbp_req_if.sink    req,
    qsbp_grp_if.source  grp,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [14:0] cfg_wr_data
);

    localparam int BCW   = BIT_COUNTER_WIDTH;
    localparam int CMP_W = BIT_COUNTER_WIDTH + 2;

    // Configuration
    logic [1:0]     version_grade_reg;
    logic [14:0]    capacity_reg;

    // Segment state
    logic [1:0]     seg_mode_reg,   seg_mode_next;
    logic [15:0]    chars_left_reg, chars_left_next;
    logic [10:0]    group_acc_reg,  group_acc_next;
    logic [1:0]     group_pos_reg,  group_pos_next;
    logic [BCW-1:0] bit_total_reg,  bit_total_next;

    // Result register: up to two group words, head first
    grp_word_t      slot0_reg, slot1_reg;
    logic [1:0]     cnt_reg;

    // Single-pass results of the current request
    grp_word_t      res_a, res_b;
    logic [1:0]     n_res;

    // Working values
    logic [4:0]     cw;
    logic [15:0]    cnt_mask;
    logic           bad;
    logic           digit_ok;
    logic [3:0]     digit;
    logic [6:0]     sym;
    logic [5:0]     sym_val;
    logic [10:0]    num_acc;
    logic [15:0]    chars_dec;
    logic           term;
    logic [BCW-1:0] bt_term;
    logic [2:0]     pad;

    logic in_fire, out_fire;

    assign in_fire   = req.valid && req.ready;
    assign out_fire  = grp.valid && grp.ready;

    // Take a new word once the result register will be empty at this edge.
    assign req.ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && grp.ready);
    assign grp.valid   = (cnt_reg != 2'd0);
    assign grp.payload = slot0_reg;

    // Shared decode of the request fields
    assign cw        = count_width(version_grade_reg, req.payload.mode_code);
    assign cnt_mask  = 16'((17'd1 << cw) - 17'd1);
    assign digit_ok  = (req.payload.char_code >= 8'h30) && (req.payload.char_code <= 8'h39);
    assign digit     = digit_ok ? 4'(req.payload.char_code - 8'h30) : 4'd0;
    assign sym       = alnum_code(req.payload.char_code);
    assign sym_val   = sym[6] ? sym[5:0] : 6'd0;
    assign num_acc   = 11'(group_acc_reg * 11'd10 + 11'(digit));
    assign chars_dec = chars_left_reg - 16'd1;
    assign term      = CMP_W'(capacity_reg) > (CMP_W'(bit_total_reg) + CMP_W'(3));
    assign bt_term   = term ? (bit_total_reg + BCW'(4)) : bit_total_reg;
    assign pad       = 3'(3'd0 - bt_term[2:0]);

    always_comb
    begin
        seg_mode_next   = seg_mode_reg;
        chars_left_next = chars_left_reg;
        group_acc_next  = group_acc_reg;
        group_pos_next  = group_pos_reg;
        bit_total_next  = bit_total_reg;
        res_a           = '0;
        res_b           = '0;
        n_res           = 2'd0;
        bad             = 1'b0;

        case (req.payload.req_type)
            REQ_HEADER:
            begin
                if (req.payload.mode_code == MODE_NUMERIC ||
                    req.payload.mode_code == MODE_ALNUM ||
                    req.payload.mode_code == MODE_BYTE)
                begin
                    // Mode indicator then count field; an open segment is dropped
                    bad             = (req.payload.seg_count >> cw) != 16'd0;
                    seg_mode_next   = req.payload.mode_code;
                    chars_left_next = req.payload.seg_count;
                    group_acc_next  = '0;
                    group_pos_next  = '0;
                    res_a.group_value = 16'(16'd1 << req.payload.mode_code);
                    res_a.group_width = 5'd4;
                    res_a.bad_input   = bad;
                    res_a.bits_so_far = 15'(bit_total_reg + BCW'(4));
                    res_b.group_value = req.payload.seg_count & cnt_mask;
                    res_b.group_width = cw;
                    res_b.bad_input   = bad;
                    bit_total_next    = bit_total_reg + BCW'(4) + BCW'(cw);
                    res_b.bits_so_far = 15'(bit_total_next);
                    n_res             = 2'd2;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            REQ_CHAR:
            begin
                if (chars_left_reg != 16'd0)
                begin
                    chars_left_next = chars_dec;
                    case (seg_mode_reg)
                        MODE_NUMERIC:
                        begin
                            bad = !digit_ok;
                            if (group_pos_reg == 2'd2)
                            begin
                                res_a.group_value = 16'(num_acc);
                                res_a.group_width = 5'd10;
                                group_acc_next    = '0;
                                group_pos_next    = '0;
                                n_res             = 2'd1;
                            end
                            else if (chars_dec == 16'd0)
                            begin
                                // Tail: one digit in 4 bits, two in 7
                                res_a.group_value = 16'(num_acc);
                                res_a.group_width = (group_pos_reg == 2'd0) ? 5'd4 : 5'd7;
                                group_acc_next    = '0;
                                group_pos_next    = '0;
                                n_res             = 2'd1;
                            end
                            else
                            begin
                                group_acc_next = num_acc;
                                group_pos_next = group_pos_reg + 2'd1;
                            end
                        end
                        MODE_ALNUM:
                        begin
                            bad = !sym[6];
                            if (group_pos_reg == 2'd1)
                            begin
                                res_a.group_value = 16'(group_acc_reg * 11'd45 + 11'(sym_val));
                                res_a.group_width = 5'd11;
                                group_acc_next    = '0;
                                group_pos_next    = '0;
                                n_res             = 2'd1;
                            end
                            else if (chars_dec == 16'd0)
                            begin
                                res_a.group_value = 16'(sym_val);
                                res_a.group_width = 5'd6;
                                n_res             = 2'd1;
                            end
                            else
                            begin
                                group_acc_next = 11'(sym_val);
                                group_pos_next = 2'd1;
                            end
                        end
                        default:
                        begin
                            res_a.group_value = 16'(req.payload.char_code);
                            res_a.group_width = 5'd8;
                            n_res             = 2'd1;
                        end
                    endcase
                    res_a.bad_input   = bad;
                    bit_total_next    = bit_total_reg + BCW'(res_a.group_width);
                    res_a.bits_so_far = 15'(bit_total_next);
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            REQ_FINISH:
            begin
                // Close the segment, then terminator (when four bits fit the capacity) and byte padding
                bad             = (chars_left_reg != 16'd0) || (group_pos_reg != 2'd0);
                chars_left_next = '0;
                group_acc_next  = '0;
                group_pos_next  = '0;
                bit_total_next  = bt_term + BCW'(pad);
                if (term)
                begin
                    res_a.group_width = 5'd4;
                    res_a.bad_input   = bad;
                    res_a.bits_so_far = 15'(bt_term);
                    if (pad != 3'd0)
                    begin
                        res_b.group_width = 5'(pad);
                        res_b.bad_input   = bad;
                        res_b.bits_so_far = 15'(bit_total_next);
                        n_res             = 2'd2;
                    end
                    else
                    begin
                        n_res = 2'd1;
                    end
                end
                else if (pad != 3'd0)
                begin
                    res_a.group_width = 5'(pad);
                    res_a.bad_input   = bad;
                    res_a.bits_so_far = 15'(bit_total_next);
                    n_res             = 2'd1;
                end
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase

        // Nothing emitted: send one empty word carrying the error flag
        if (n_res == 2'd0)
        begin
            res_a             = '0;
            res_a.bad_input   = bad;
            res_a.bits_so_far = 15'(bit_total_reg);
            n_res             = 2'd1;
        end

        if (n_res == 2'd1)
        begin
            res_a.last_of_run = 1'b1;
        end
        else
        begin
            res_b.last_of_run = 1'b1;
        end
    end

    // Control state, configuration and segment state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_grade_reg <= '0;
            capacity_reg      <= CAPACITY_RESET;
            seg_mode_reg      <= MODE_NUMERIC;
            chars_left_reg    <= '0;
            group_acc_reg     <= '0;
            group_pos_reg     <= '0;
            bit_total_reg     <= '0;
            cnt_reg           <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_VERSION_GRADE: version_grade_reg <= cfg_wr_data[1:0];
                    CFG_CAPACITY_BITS: capacity_reg      <= cfg_wr_data;
                    default:           capacity_reg      <= capacity_reg;
                endcase
            end
            if (in_fire)
            begin
                seg_mode_reg   <= seg_mode_next;
                chars_left_reg <= chars_left_next;
                group_acc_reg  <= group_acc_next;
                group_pos_reg  <= group_pos_next;
                bit_total_reg  <= bit_total_next;
                cnt_reg        <= n_res;
            end
            else if (out_fire)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    // Result slots: load on accept, advance on each word taken
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            slot0_reg <= res_a;
            slot1_reg <= res_b;
        end
        else if (out_fire)
        begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule
